/* sv/lhq_pkg.sv */
`timescale 1ns / 1ps
// shared constants, derived widths and the query state type for the
// latency histogram quantile block; no dependencies
package lhq_pkg;

  localparam int NUM_BINS   = 65536;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int CNT_W      = 32;
  localparam int IDX_W      = 17;
  localparam int Q_W        = 17;
  localparam int LATE_W     = 64;
  localparam int MAX_W      = 63;
  localparam int ACC_W      = CNT_W + BIN_W;

  localparam longint unsigned NS_PER_BIN = 64'd1000;
  localparam longint unsigned Q_ONE      = 64'd65536;

  // adds below this lateness land in a real bin
  localparam longint unsigned BIN_LIMIT  = 64'(NUM_BINS) * NS_PER_BIN;
  localparam int X_W        = $clog2(BIN_LIMIT);

  // divide by 1000 as multiply by reciprocal, exact for x < 2**X_W
  localparam int RECIP_SH   = X_W + 10;
  localparam int RECIP_W    = RECIP_SH - 9;
  localparam longint unsigned RECIP_L =
      ((64'd1 << RECIP_SH) + NS_PER_BIN - 64'd1) / NS_PER_BIN;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAIN,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_WALK,
    S_EMIT
  } lhq_state_t;

endpackage

/* sv/lhq_ram.sv */
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module lhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/latency_histogram_quantile.sv */
`timescale 1ns / 1ps
// lateness histogram with quantile query: bins in lhq_ram, counters in flops; needs lhq_pkg
// add: one transfer per cycle while in S_IDLE, no result; bin update is a 3-stage multiply/read/write pipe
// query: waits for queued adds to drain, forms the target in S_MUL_LO, S_MUL_HI and S_SUM, then walks
//   the bins (one bin per cycle) and loads the result register in S_EMIT; input held off meanwhile
// reset: a clearing pass zeroes all NUM_BINS (65536) bins, one per cycle, in_ready low;
//   counters and maximum clear at once
module latency_histogram_quantile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [lhq_pkg::LATE_W-1:0] in_late_ns,
  input  logic [lhq_pkg::Q_W-1:0]       in_quantile_q16,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lhq_pkg::IDX_W-1:0]     out_bucket_index,
  output logic [63:0]                   out_sample_count,
  output logic [63:0]                   out_overflow_count,
  output logic [lhq_pkg::MAX_W-1:0]     out_max_late_ns
);
  import lhq_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int PROD_W = X_W + RECIP_W;

  lhq_state_t state_r, state_nxt;

  // running counters
  logic [63:0]      tot_r;
  logic [63:0]      ovf_r;
  logic [MAX_W-1:0] max_r;

  // clearing pass
  logic [BIN_W-1:0] clr_addr_r;

  // add pipeline: s1 multiply, s2 ram read, s3 modify and write
  logic             s1_vld_r, s2_vld_r, s3_vld_r;
  logic [X_W-1:0]   s1_x_r;
  logic [BIN_W-1:0] s2_bin_r, s3_bin_r;
  logic [PROD_W-1:0] s1_prod;

  // last write, for forwarding into s3
  logic             wl_vld_r;
  logic [BIN_W-1:0] wl_addr_r;
  logic [CNT_W-1:0] wl_data_r;

  // query path
  logic             q_one_r;
  logic [15:0]      q_frac_r;
  logic [47:0]      pp_lo_r, pp_hi_r;
  logic [47:0]      pp;
  logic [31:0]      mul_b;
  logic [79:0]      sum80;
  logic [63:0]      target_r;
  logic [BIN_W:0]   walk_addr_r;
  logic             rd_pend_r;
  logic [BIN_W-1:0] rd_idx_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [BIN_W:0]   res_idx_r;

  // output register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [63:0]      out_tot_r, out_ovf_r;
  logic [MAX_W-1:0] out_max_r;

  // ram ports
  logic             ram_wr_en, ram_rd_en;
  logic [BIN_W-1:0] ram_wr_addr, ram_rd_addr;
  logic [CNT_W-1:0] ram_wr_data, ram_rd_data;

  // decoded handshake and control
  logic             in_fire, add_fire, qry_fire;
  logic             late_neg, in_range;
  logic             walk_rd, walk_hit, walk_end, out_load;
  logic [CNT_W-1:0] s3_cur, s3_new;

  lhq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_fire  = in_valid && in_ready;
  assign add_fire = in_fire && !in_action;
  assign qry_fire = in_fire && in_action;

  // negative lateness goes to bin 0; too late counts as overflow
  assign late_neg = in_late_ns[LATE_W-1];
  assign in_range = late_neg || (64'(in_late_ns[LATE_W-2:0]) < BIN_LIMIT);

  // bin = x / 1000 via reciprocal
  assign s1_prod  = PROD_W'(s1_x_r) * PROD_W'(RECIP);

  // forward the write of the previous cycle, the ram read missed it
  assign s3_cur = (wl_vld_r && (wl_addr_r == s3_bin_r)) ? wl_data_r : ram_rd_data;
  assign s3_new = (s3_cur == {CNT_W{1'b1}}) ? s3_cur : s3_cur + CNT_W'(1);

  // shared 16x32 multiplier for the two partial products of q * n
  assign mul_b = (state_r == S_MUL_HI) ? tot_r[63:32] : tot_r[31:0];
  assign pp    = 48'(q_frac_r) * 48'(mul_b);
  assign sum80 = {pp_hi_r, 32'd0} + {32'd0, pp_lo_r};

  // walk: accumulate returned bin and test against the target
  assign acc_nxt  = acc_r + ACC_W'(ram_rd_data);
  assign walk_hit = rd_pend_r && (64'(acc_nxt) >= target_r);
  assign walk_end = rd_pend_r && (rd_idx_r == BIN_W'(NUM_BINS - 1));

  // ram port steering; walk never overlaps the add pipeline
  assign ram_rd_en   = s2_vld_r || walk_rd;
  assign ram_rd_addr = walk_rd ? walk_addr_r[BIN_W-1:0] : s2_bin_r;
  assign ram_wr_en   = (state_r == S_CLEAR) || s3_vld_r;
  assign ram_wr_addr = (state_r == S_CLEAR) ? clr_addr_r : s3_bin_r;
  assign ram_wr_data = (state_r == S_CLEAR) ? '0 : s3_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    walk_rd   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == BIN_W'(NUM_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (qry_fire) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // let queued adds land before reading bins
        if (!s1_vld_r && !s2_vld_r && !s3_vld_r) begin
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_SUM;
      S_SUM:    state_nxt = S_WALK;
      S_WALK: begin
        walk_rd = (walk_addr_r < (BIN_W + 1)'(NUM_BINS));
        if (walk_hit || walk_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_load = !out_valid_r || out_ready;
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r       <= '0;
      ovf_r       <= '0;
      max_r       <= '0;
      clr_addr_r  <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      wl_vld_r    <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + BIN_W'(1);
      end
      if (add_fire) begin
        tot_r <= tot_r + 64'd1;
        if (!in_range) begin
          ovf_r <= ovf_r + 64'd1;
        end
        if (!late_neg && (in_late_ns[LATE_W-2:0] > max_r)) begin
          max_r <= in_late_ns[LATE_W-2:0];
        end
      end
      s1_vld_r  <= add_fire && in_range;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      wl_vld_r  <= s3_vld_r;
      rd_pend_r <= walk_rd;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (add_fire) begin
      s1_x_r <= late_neg ? '0 : in_late_ns[X_W-1:0];
    end
    s2_bin_r  <= s1_prod[RECIP_SH +: BIN_W];
    s3_bin_r  <= s2_bin_r;
    wl_addr_r <= s3_bin_r;
    wl_data_r <= s3_new;

    if (qry_fire) begin
      // quantiles above one saturate to one
      q_one_r  <= (64'(in_quantile_q16) >= Q_ONE);
      q_frac_r <= in_quantile_q16[15:0];
    end
    if (state_r == S_MUL_LO) begin
      pp_lo_r <= pp;
    end
    if (state_r == S_MUL_HI) begin
      pp_hi_r <= pp;
    end
    if (state_r == S_SUM) begin
      target_r    <= q_one_r ? tot_r : sum80[79:16];
      walk_addr_r <= '0;
      acc_r       <= '0;
    end
    if (walk_rd) begin
      walk_addr_r <= walk_addr_r + (BIN_W + 1)'(1);
      rd_idx_r    <= walk_addr_r[BIN_W-1:0];
    end
    if (rd_pend_r) begin
      acc_r <= acc_nxt;
    end
    if (state_r == S_WALK) begin
      priority if (walk_hit) begin
        res_idx_r <= {1'b0, rd_idx_r};
      end else if (walk_end) begin
        // no bin reaches the target
        res_idx_r <= (BIN_W + 1)'(NUM_BINS);
      end
    end
    if (out_load) begin
      out_idx_r <= IDX_W'(res_idx_r);
      out_tot_r <= tot_r;
      out_ovf_r <= ovf_r;
      out_max_r <= max_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bucket_index   = out_idx_r;
  assign out_sample_count   = out_tot_r;
  assign out_overflow_count = out_ovf_r;
  assign out_max_late_ns    = out_max_r;

endmodule

/* bench/latency_histogram_quantile_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for latency_histogram_quantile: directed table, then random
// sample/query traffic checked against an in-bench histogram; depends on lhq_pkg
module latency_histogram_quantile_tb;
  import lhq_pkg::*;

  // transfer codes on in_action
  localparam bit ACT_ADD   = 1'b0;
  localparam bit ACT_QUERY = 1'b1;

  localparam int RANDOM_ITEMS = 550;
  localparam int PHASES       = 3;
  // extra cycles after the last result, enough for a trailing add in the pipe
  localparam int DRAIN_CYCLES = 32;
  // slowest correct run: clearing pass, then every item a query that walks all
  // bins behind long receiver stalls; taken four times over
  localparam longint unsigned CYCLE_LIMIT =
      64'd4 * (64'(NUM_BINS) + 64'(RANDOM_ITEMS + 32) * (64'(NUM_BINS) + 64'd256));
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [IDX_W-1:0] bucket;
    logic [63:0]      count;
    logic [63:0]      overflow;
    logic [MAX_W-1:0] peak;
  } quantile_result_t;

  typedef struct {
    bit               action;
    logic [63:0]      late;
    logic [Q_W-1:0]   q;
    bit               typed;
    quantile_result_t result;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_action;
  logic signed [LATE_W-1:0] in_late_ns;
  logic [Q_W-1:0]           in_quantile_q16;
  logic                     out_valid;
  logic                     out_ready;
  logic [IDX_W-1:0]         out_bucket_index;
  logic [63:0]              out_sample_count;
  logic [63:0]              out_overflow_count;
  logic [MAX_W-1:0]         out_max_late_ns;

  latency_histogram_quantile uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_late_ns        (in_late_ns),
    .in_quantile_q16   (in_quantile_q16),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bucket_index  (out_bucket_index),
    .out_sample_count  (out_sample_count),
    .out_overflow_count(out_overflow_count),
    .out_max_late_ns   (out_max_late_ns)
  );

  // histogram image kept by the bench
  int unsigned     hist_bins [NUM_BINS];
  longint unsigned hist_total;
  longint unsigned hist_overflow;
  longint unsigned hist_peak;

  quantile_result_t pending_quantiles[$];
  stim_row_t        directed_rows[$];

  int              error_count;
  longint unsigned cycle_count;
  int              send_idle_pct;
  int              recv_idle_pct;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- histogram

  // one lateness sample: negative goes to bin 0 and leaves the peak alone,
  // past the last bin counts as overflow, full bins hold at all ones
  function automatic void image_add_sample(input logic [63:0] late);
    longint unsigned raw;
    longint unsigned bin;
    raw = late;
    bin = 0;
    if (!raw[63]) begin
      if (raw > hist_peak) hist_peak = raw;
      bin = raw / NS_PER_BIN;
    end
    if (bin >= 64'(NUM_BINS)) begin
      hist_overflow++;
    end else if (hist_bins[bin] != 32'hFFFF_FFFF) begin
      hist_bins[bin]++;
    end
    hist_total++;
  endfunction

  // target = floor(q * n / 2**16), q held at 1.0; first bin whose running
  // sum reaches it, NUM_BINS when the bins never get there
  function automatic quantile_result_t hist_quantile(input logic [Q_W-1:0] q);
    longint unsigned qq;
    longint unsigned target;
    longint unsigned acc;
    longint unsigned idx;
    quantile_result_t r;
    qq = 64'(q);
    if (qq > Q_ONE) qq = Q_ONE;
    target = qq * (hist_total >> 16) + ((qq * (hist_total & 64'hFFFF)) >> 16);
    acc = 0;
    idx = 64'(NUM_BINS);
    for (int i = 0; i < NUM_BINS; i++) begin
      acc += 64'(hist_bins[i]);
      if (acc >= target) begin
        idx = 64'(i);
        break;
      end
    end
    r.bucket   = idx[IDX_W-1:0];
    r.count    = hist_total;
    r.overflow = hist_overflow;
    r.peak     = hist_peak[MAX_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("mismatch %s: got %0h, expected %0h (cycle %0d)",
               what, got, want, cycle_count);
    end
  endtask

  // result transfers are compared with the oldest query still waiting
  always @(posedge clk) begin
    quantile_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_quantiles.size() == 0) begin
        report_mismatch("result with no query waiting", 64'(out_bucket_index), 64'd0);
      end else begin
        want = pending_quantiles.pop_front();
        if (out_bucket_index !== want.bucket)
          report_mismatch("bucket_index", 64'(out_bucket_index), 64'(want.bucket));
        if (out_sample_count !== want.count)
          report_mismatch("sample_count", out_sample_count, want.count);
        if (out_overflow_count !== want.overflow)
          report_mismatch("overflow_count", out_overflow_count, want.overflow);
        if (out_max_late_ns !== want.peak)
          report_mismatch("max_late_ns", 64'(out_max_late_ns), 64'(want.peak));
      end
    end
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_quantiles.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving

  // receiver side: ready redrawn every falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one input transfer; entered and left at a falling edge. valid stays high
  // into the next call so back-to-back items keep a single assignment per edge
  task automatic send_item(input bit action, input logic [63:0] late,
                           input logic [Q_W-1:0] q, input bit typed,
                           input quantile_result_t typed_result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= action;
    in_late_ns      <= late;
    in_quantile_q16 <= q;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: update the image or queue the answer
    if (action == ACT_QUERY) begin
      pending_quantiles.push_back(typed ? typed_result : hist_quantile(q));
    end else begin
      image_add_sample(late);
    end
    @(negedge clk);
  endtask

  task automatic add_row(input bit action, input logic [63:0] late,
                         input logic [Q_W-1:0] q, input bit typed,
                         input logic [IDX_W-1:0] bucket, input logic [63:0] count,
                         input logic [63:0] overflow, input logic [MAX_W-1:0] peak);
    stim_row_t row;
    row.action          = action;
    row.late            = late;
    row.q               = q;
    row.typed           = typed;
    row.result.bucket   = bucket;
    row.result.count    = count;
    row.result.overflow = overflow;
    row.result.peak     = peak;
    directed_rows.push_back(row);
  endtask

  // random traffic: mostly small latenesses so quantile walks end early, a few
  // negative, full-width and bin-edge samples, and queries mostly below the
  // overflow fraction so that only a handful walk every bin
  task automatic draw_item(output bit action, output logic [63:0] late,
                           output logic [Q_W-1:0] q);
    int unsigned pick;
    longint unsigned bin;
    action = ($urandom_range(99) < 20) ? ACT_QUERY : ACT_ADD;
    pick   = $urandom_range(99);
    bin    = 64'($urandom_range(NUM_BINS - 1));
    if (pick < 80) begin
      late = 64'($urandom_range(199999));
    end else if (pick < 90) begin
      late = {1'b1, 31'($urandom), $urandom};
    end else if (pick < 96) begin
      late = {$urandom, $urandom};
    end else begin
      case ($urandom_range(3))
        0:       late = bin * NS_PER_BIN;
        1:       late = bin * NS_PER_BIN + 64'd999;
        2:       late = BIN_LIMIT + 64'($urandom_range(999));
        default: late = BIN_LIMIT - 64'd1;
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 85)      q = Q_W'($urandom_range(58000));
    else if (pick < 95) q = Q_W'($urandom_range(65535));
    else                q = Q_W'($urandom);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    bit               act;
    logic [63:0]      late;
    logic [Q_W-1:0]   q;
    quantile_result_t none;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_ADD;
    in_late_ns      = '0;
    in_quantile_q16 = '0;
    out_ready       = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    send_idle_pct   = 30;
    recv_idle_pct   = 51;
    hist_total      = 0;
    hist_overflow   = 0;
    hist_peak       = 0;
    none            = '0;
    foreach (hist_bins[i]) hist_bins[i] = 0;

    // queries on the empty store: target is zero, bin 0, all counters zero;
    // late_ns is noise here, and all-ones q stands for a quantile above one
    add_row(ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 17'd0,     1, '0, '0, '0, '0);
    add_row(ACT_QUERY, 64'h0,                  17'd65536, 1, '0, '0, '0, '0);
    add_row(ACT_QUERY, 64'h8000_0000_0000_0000, 17'h1FFFF, 1, '0, '0, '0, '0);
    // adds at the extremes; q is noise on an add
    add_row(ACT_ADD, 64'd0,                    17'h1FFFF, 0, '0, '0, '0, '0);
    add_row(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF,  17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_ADD, 64'h8000_0000_0000_0000,  17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_ADD, 64'd999,                  17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_ADD, 64'd1000,                 17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_ADD, 64'h7FFF_FFFF_FFFF_FFFF,  17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_ADD, BIN_LIMIT - 64'd1,        17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_ADD, BIN_LIMIT,                17'd0,     0, '0, '0, '0, '0);
    // quantiles over that mix; 1.0 and above never reach the target here
    add_row(ACT_QUERY, 64'd0,                  17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 17'd1,    0, '0, '0, '0, '0);
    add_row(ACT_QUERY, 64'h5555_5555_5555_5555, 17'd32768, 0, '0, '0, '0, '0);
    add_row(ACT_QUERY, 64'd0,                  17'd65535, 0, '0, '0, '0, '0);
    add_row(ACT_QUERY, 64'd0,                  17'd65536, 0, '0, '0, '0, '0);
    add_row(ACT_QUERY, 64'd0,                  17'h10001, 0, '0, '0, '0, '0);
    add_row(ACT_ADD,   64'd500,                17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_ADD,   64'd1500,               17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_ADD,   64'd5000,               17'd0,     0, '0, '0, '0, '0);
    add_row(ACT_QUERY, 64'd0,                  17'd16384, 0, '0, '0, '0, '0);
    add_row(ACT_QUERY, 64'd0,                  17'd49152, 0, '0, '0, '0, '0);
    // saturated bins and wrapped counters need 2**32 and 2**64 adds, out of reach

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    // the clearing pass holds in_ready low; send_item simply waits it out

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].action, directed_rows[i].late, directed_rows[i].q,
                directed_rows[i].typed, directed_rows[i].result);
    end

    // idle mixes: sender-light/receiver-heavy, swapped, then none
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 30; recv_idle_pct = 51; end
        1:       begin send_idle_pct = 51; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      repeat (RANDOM_ITEMS / PHASES) begin
        draw_item(act, late, q);
        send_item(act, late, q, 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    while (pending_quantiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lhq_pkg.sv
sv/lhq_ram.sv
sv/latency_histogram_quantile.sv
bench/latency_histogram_quantile_tb.sv
